>>> src/llcp_pkg.sv
// Shared types and constants for the line-line closest points block.
// No dependencies.
package llcp_pkg;

    localparam int LANE_BITS = 32;

    typedef struct packed {
        logic valid;
        logic degen;
    } llcp_qctl_t;

endpackage

>>> src/line_line_closest_points.sv
// Closest points between two 3D lines, each given by two signed fixed-point points. The block
// takes one beat per cycle while s_tready is high and returns one result beat per input beat,
// in order; with m_tready held high it sustains one item every cycle. Each item passes three
// pipelined multiplier stages (built from 32x32 lane products) and the bit-per-stage divider
// that yields COORD_BITS+1 quotient bits. A 2-entry queue sits between the input side and the
// pipeline, and the whole pipeline holds when a finished result waits. m_tuser is 0, with all
// points 0, for a zero-length line or parallel lines; far points saturate to the coordinate
// range.
module line_line_closest_points
    import llcp_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // a0_x a0_y a0_z a1_x a1_y a1_z b0_x b0_y b0_z b1_x b1_y b1_z
    input  logic [((12 * COORD_BITS + 7) / 8) * 8-1:0] s_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // near_a_x near_a_y near_a_z near_b_x near_b_y near_b_z
    output logic [((6 * COORD_BITS + 7) / 8) * 8-1:0]  m_tdata,
    // found
    output logic                                        m_tuser
);

    localparam int QDW = 6 * COORD_BITS + 9 * (COORD_BITS + 1);

    llcp_qctl_t     q_ctl;
    logic [QDW-1:0] q_data;
    logic           pop;

    llcp_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .pop      (pop),
        .q_ctl    (q_ctl),
        .q_data   (q_data)
    );

    llcp_back #(.COORD_BITS(COORD_BITS)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_ctl    (q_ctl),
        .q_data   (q_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> src/llcp_delay.sv
// Enabled shift line that carries sideband data alongside the arithmetic pipes.
// No dependencies.
module llcp_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] sr_reg [D];

    always_ff @(posedge aclk) begin
        if (en) begin
            sr_reg[0] <= din;
            for (int i = 1; i < D; i++) begin
                sr_reg[i] <= sr_reg[i-1];
            end
        end
    end

    assign dout = sr_reg[D-1];

endmodule

>>> src/llcp_mul.sv
// Pipelined signed multiplier built from 32x32 lane products, one chunk of b per stage pair.
// Depends on llcp_pkg. Input register, then a product and an accumulate register per chunk, then the output register.
module llcp_mul
    import llcp_pkg::*;
#(
    parameter int WA = 33,
    parameter int WB = 33
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [WA-1:0]    a,
    input  logic signed [WB-1:0]    b,
    output logic signed [WA+WB-1:0] p
);

    localparam int LA = (WA + LANE_BITS - 1) / LANE_BITS;
    localparam int NB = (WB + LANE_BITS - 1) / LANE_BITS;
    localparam int AW = LA * LANE_BITS;
    localparam int BW = NB * LANE_BITS;
    localparam int RW = AW + BW;
    localparam int PW = WA + WB;

    logic [WA-1:0] a_mag;
    logic [WB-1:0] b_mag;

    logic [AW-1:0] a_reg [NB];
    logic [BW-1:0] b_reg [NB];
    logic          s_reg [NB+1];
    logic [RW-1:0] c_reg [1:NB];
    logic signed [PW-1:0] p_reg;

    assign a_mag = a[WA-1] ? WA'(-a) : WA'(a);
    assign b_mag = b[WB-1] ? WB'(-b) : WB'(b);

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg[0] <= AW'(a_mag);
            b_reg[0] <= BW'(b_mag);
            s_reg[0] <= a[WA-1] ^ b[WB-1];
        end
    end

    for (genvar k = 0; k < NB; k++) begin : g_chunk
        logic [2*LANE_BITS-1:0] pp_reg [LA];
        logic                   sp_reg;
        logic [RW-1:0]          cp_reg;
        logic [RW-1:0]          c_in;
        logic [RW-1:0]          ev;
        logic [RW-1:0]          od;

        if (k == 0) begin : g_first
            assign c_in = '0;
        end else begin : g_next
            assign c_in = c_reg[k];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int l = 0; l < LA; l++) begin
                    pp_reg[l] <= a_reg[k][l*LANE_BITS +: LANE_BITS]
                               * b_reg[k][k*LANE_BITS +: LANE_BITS];
                end
                sp_reg <= s_reg[k];
                cp_reg <= c_in;
            end
        end

        // even and odd lanes do not overlap among themselves
        always_comb begin
            ev = '0;
            od = '0;
            for (int l = 0; l < LA; l++) begin
                if (l % 2 == 0) begin
                    ev[l*LANE_BITS +: 2*LANE_BITS] = pp_reg[l];
                end else begin
                    od[l*LANE_BITS +: 2*LANE_BITS] = pp_reg[l];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                c_reg[k+1] <= cp_reg + (ev << (k*LANE_BITS)) + (od << (k*LANE_BITS));
                s_reg[k+1] <= sp_reg;
            end
        end

        if (k < NB - 1) begin : g_fwd
            logic [AW-1:0] ap_reg;
            logic [BW-1:0] bp_reg;
            always_ff @(posedge aclk) begin
                if (en) begin
                    ap_reg     <= a_reg[k];
                    bp_reg     <= b_reg[k];
                    a_reg[k+1] <= ap_reg;
                    b_reg[k+1] <= bp_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= s_reg[NB] ? -$signed(c_reg[NB][PW-1:0]) : $signed(c_reg[NB][PW-1:0]);
        end
    end

    assign p = p_reg;

endmodule

>>> src/llcp_div.sv
// Pipelined restoring divider, one quotient bit per stage, round half up, clamp to 2^(QB-1).
// No dependencies. Input register, one register per quotient bit, then a rounding and clamping output register.
module llcp_div #(
    parameter int NWID = 170,
    parameter int DWID = 137,
    parameter int QB   = 33
) (
    input  logic            aclk,
    input  logic            en,
    input  logic [NWID-1:0] num,
    input  logic [DWID-1:0] den,
    output logic [QB-1:0]   quo
);

    localparam int RWID = ((NWID > DWID + QB) ? NWID : DWID + QB) + 1;
    localparam logic [QB:0] LIM = (QB+1)'(1) << (QB - 1);

    logic [RWID-1:0] r_reg   [QB+1];
    logic [DWID-1:0] d_reg   [QB+1];
    logic            ovf_reg [QB+1];
    logic [QB-1:0]   q_reg   [1:QB];
    logic [QB-1:0]   quo_reg;
    logic            rnd;
    logic [QB:0]     qr;

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]   <= RWID'(num);
            d_reg[0]   <= den;
            ovf_reg[0] <= RWID'(num) >= (RWID'(den) << QB);
        end
    end

    for (genvar s = 0; s < QB; s++) begin : g_step
        localparam int SH = QB - 1 - s;
        logic [RWID-1:0] dsh;
        logic            ge;
        logic [QB-1:0]   q_in;

        assign dsh = RWID'(d_reg[s]) << SH;
        assign ge  = r_reg[s] >= dsh;

        if (s == 0) begin : g_first
            assign q_in = '0;
        end else begin : g_next
            assign q_in = q_reg[s];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[s+1]   <= ge ? r_reg[s] - dsh : r_reg[s];
                d_reg[s+1]   <= d_reg[s];
                ovf_reg[s+1] <= ovf_reg[s];
                q_reg[s+1]   <= {q_in[QB-2:0], ge};
            end
        end
    end

    assign rnd = (r_reg[QB] << 1) >= RWID'(d_reg[QB]);
    assign qr  = (QB+1)'(q_reg[QB]) + (QB+1)'(rnd);

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg <= (ovf_reg[QB] || qr >= LIM) ? LIM[QB-1:0] : qr[QB-1:0];
        end
    end

    assign quo = quo_reg;

endmodule

>>> src/llcp_front.sv
// Front end: accepts beats, forms difference vectors, flags zero-length lines, 2-entry queue.
// Depends on llcp_pkg.
module llcp_front
    import llcp_pkg::*;
#(
    parameter  int COORD_BITS = 32,
    localparam int IW  = ((12 * COORD_BITS + 7) / 8) * 8,
    localparam int QDW = 6 * COORD_BITS + 9 * (COORD_BITS + 1)
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [IW-1:0]  s_tdata,
    input  logic           pop,
    output llcp_qctl_t     q_ctl,
    output logic [QDW-1:0] q_data
);

    localparam int CB    = COORD_BITS;
    localparam int DW    = CB + 1;
    localparam int DEPTH = 2;

    logic [CB-1:0] a0 [3];
    logic [CB-1:0] a1 [3];
    logic [CB-1:0] b0 [3];
    logic [CB-1:0] b1 [3];
    logic [DW-1:0] d21 [3];
    logic [DW-1:0] d43 [3];
    logic [DW-1:0] d13 [3];
    logic          deg_a;
    logic          deg_b;
    logic          push;
    logic          pop_go;
    logic [QDW:0]  ent;

    logic [QDW:0]  mem_reg [DEPTH];
    logic          wp_reg;
    logic          rp_reg;
    logic [1:0]    cnt_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a0[i]  = s_tdata[i*CB +: CB];
            a1[i]  = s_tdata[(3+i)*CB +: CB];
            b0[i]  = s_tdata[(6+i)*CB +: CB];
            b1[i]  = s_tdata[(9+i)*CB +: CB];
            d21[i] = {a1[i][CB-1], a1[i]} - {a0[i][CB-1], a0[i]};
            d43[i] = {b1[i][CB-1], b1[i]} - {b0[i][CB-1], b0[i]};
            d13[i] = {a0[i][CB-1], a0[i]} - {b0[i][CB-1], b0[i]};
        end
        deg_a = (d21[0] == '0) && (d21[1] == '0) && (d21[2] == '0);
        deg_b = (d43[0] == '0) && (d43[1] == '0) && (d43[2] == '0);
        ent   = {deg_a | deg_b, d13[2], d13[1], d13[0], d43[2], d43[1], d43[0],
                 d21[2], d21[1], d21[0], b0[2], b0[1], b0[0], a0[2], a0[1], a0[0]};
    end

    assign s_tready = cnt_reg != 2'(DEPTH);
    assign push     = s_tvalid && s_tready;
    assign pop_go   = pop && (cnt_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= !wp_reg;
            end
            if (pop_go) begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop_go);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= ent;
        end
    end

    assign q_ctl.valid = cnt_reg != '0;
    assign q_ctl.degen = mem_reg[rp_reg][QDW];
    assign q_data      = mem_reg[rp_reg][QDW-1:0];

    ap_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop_go) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count did not follow a push");

endmodule

>>> src/llcp_back.sv
// Back end: dot products, determinant and numerators, offsets, division, placement, output register.
// Depends on llcp_pkg, llcp_mul, llcp_div, llcp_delay.
module llcp_back
    import llcp_pkg::*;
#(
    parameter  int COORD_BITS = 32,
    localparam int QDW = 6 * COORD_BITS + 9 * (COORD_BITS + 1),
    localparam int OW  = ((6 * COORD_BITS + 7) / 8) * 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  llcp_qctl_t     q_ctl,
    input  logic [QDW-1:0] q_data,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [OW-1:0]  m_tdata,
    output logic           m_tuser
);

    localparam int CB  = COORD_BITS;
    localparam int DW  = CB + 1;
    localparam int PW  = 2 * DW;
    localparam int EW  = PW + 2;
    localparam int FW  = 2 * EW;
    localparam int NW  = FW + 1;
    localparam int TW  = NW + DW;
    localparam int QB  = CB + 1;
    localparam int L1  = 2 * ((DW + LANE_BITS - 1) / LANE_BITS) + 2;
    localparam int L2  = 2 * ((EW + LANE_BITS - 1) / LANE_BITS) + 2;
    localparam int L3  = 2 * ((DW + LANE_BITS - 1) / LANE_BITS) + 2;
    localparam int DL  = QB + 2;
    localparam int TOT = L1 + L2 + L3 + DL + 3;
    localparam int S1W = 6 * CB + 6 * DW + 1;
    localparam int S3W = 6 * CB + NW + 2;
    localparam int S4W = 6 * CB + 8;
    localparam logic signed [CB+1:0] HI = {3'b000, {(CB-1){1'b1}}};
    localparam logic signed [CB+1:0] LO = {3'b111, {(CB-1){1'b0}}};

    logic en;

    // dot products
    logic signed [DW-1:0] d21 [3];
    logic signed [DW-1:0] d43 [3];
    logic signed [DW-1:0] d13 [3];
    logic signed [DW-1:0] opu [15];
    logic signed [DW-1:0] opv [15];
    logic signed [PW-1:0] p1  [15];
    logic signed [EW-1:0] e_reg [5];
    logic [S1W-1:0]       sb1_out;

    // determinant and numerators
    logic signed [EW-1:0] m2a [6];
    logic signed [EW-1:0] m2b [6];
    logic signed [FW-1:0] p2  [6];
    logic signed [NW-1:0] den_reg;
    logic signed [NW-1:0] numa_reg;
    logic signed [NW-1:0] numb_reg;
    logic [S1W-1:0]       sb2_out;

    // offsets
    logic signed [DW-1:0] d21b [3];
    logic signed [DW-1:0] d43b [3];
    logic signed [TW-1:0] p3   [6];
    logic [TW-1:0]        tm_reg [6];
    logic [5:0]           ts_reg;
    logic [S3W-1:0]       sb3_in;
    logic [S3W-1:0]       sb3_out;

    // division and placement
    logic [QB-1:0]         quo [6];
    logic [S4W-1:0]        sb4_out;
    logic signed [CB+1:0]  sum [6];
    logic [CB-1:0]         near [6];
    logic                  found;

    logic [TOT-1:0] vld_reg;
    logic           m_tvalid_reg;
    logic           m_found_reg;
    logic [CB-1:0]  m_near_reg [6];

    assign en  = !m_tvalid_reg || m_tready;
    assign pop = en;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d21[i] = q_data[6*CB + i*DW +: DW];
            d43[i] = q_data[6*CB + (3+i)*DW +: DW];
            d13[i] = q_data[6*CB + (6+i)*DW +: DW];
            opu[i]    = d13[i];  opv[i]    = d43[i];
            opu[3+i]  = d43[i];  opv[3+i]  = d21[i];
            opu[6+i]  = d13[i];  opv[6+i]  = d21[i];
            opu[9+i]  = d43[i];  opv[9+i]  = d43[i];
            opu[12+i] = d21[i];  opv[12+i] = d21[i];
        end
    end

    for (genvar j = 0; j < 15; j++) begin : g_m1
        llcp_mul #(.WA(DW), .WB(DW)) u_mul (
            .aclk (aclk), .en (en), .a (opu[j]), .b (opv[j]), .p (p1[j])
        );
    end

    // e: 1343, 4321, 1321, 4343, 2121
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 5; j++) begin
                e_reg[j] <= EW'(p1[3*j]) + EW'(p1[3*j+1]) + EW'(p1[3*j+2]);
            end
        end
    end

    llcp_delay #(.W(S1W), .D(L1 + 1)) u_sb1 (
        .aclk (aclk), .en (en), .din ({q_ctl.degen, q_data[S1W-2:0]}), .dout (sb1_out)
    );

    always_comb begin
        m2a[0] = e_reg[4];  m2b[0] = e_reg[3];
        m2a[1] = e_reg[1];  m2b[1] = e_reg[1];
        m2a[2] = e_reg[0];  m2b[2] = e_reg[1];
        m2a[3] = e_reg[2];  m2b[3] = e_reg[3];
        m2a[4] = e_reg[0];  m2b[4] = e_reg[4];
        m2a[5] = e_reg[1];  m2b[5] = e_reg[2];
    end

    for (genvar j = 0; j < 6; j++) begin : g_m2
        llcp_mul #(.WA(EW), .WB(EW)) u_mul (
            .aclk (aclk), .en (en), .a (m2a[j]), .b (m2b[j]), .p (p2[j])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg  <= NW'(p2[0]) - NW'(p2[1]);
            numa_reg <= NW'(p2[2]) - NW'(p2[3]);
            numb_reg <= NW'(p2[4]) - NW'(p2[5]);
        end
    end

    llcp_delay #(.W(S1W), .D(L2 + 1)) u_sb2 (
        .aclk (aclk), .en (en), .din (sb1_out), .dout (sb2_out)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d21b[i] = sb2_out[6*CB + i*DW +: DW];
            d43b[i] = sb2_out[6*CB + (3+i)*DW +: DW];
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_m3
        llcp_mul #(.WA(NW), .WB(DW)) u_mul_a (
            .aclk (aclk), .en (en), .a (numa_reg), .b (d21b[i]), .p (p3[i])
        );
        llcp_mul #(.WA(NW), .WB(DW)) u_mul_b (
            .aclk (aclk), .en (en), .a (numb_reg), .b (d43b[i]), .p (p3[3+i])
        );
    end

    assign sb3_in = {den_reg == '0, sb2_out[S1W-1], den_reg, sb2_out[6*CB-1:0]};

    llcp_delay #(.W(S3W), .D(L3 + 1)) u_sb3 (
        .aclk (aclk), .en (en), .din (sb3_in), .dout (sb3_out)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 6; k++) begin
                tm_reg[k] <= p3[k][TW-1] ? TW'(-p3[k]) : TW'(p3[k]);
                ts_reg[k] <= p3[k][TW-1];
            end
        end
    end

    for (genvar k = 0; k < 6; k++) begin : g_div
        llcp_div #(.NWID(TW), .DWID(NW), .QB(QB)) u_div (
            .aclk (aclk), .en (en), .num (tm_reg[k]),
            .den (sb3_out[6*CB +: NW]), .quo (quo[k])
        );
    end

    llcp_delay #(.W(S4W), .D(DL)) u_sb4 (
        .aclk (aclk),
        .en   (en),
        .din  ({ts_reg, sb3_out[6*CB+NW+1], sb3_out[6*CB+NW], sb3_out[6*CB-1:0]}),
        .dout (sb4_out)
    );

    assign found = !sb4_out[6*CB] && !sb4_out[6*CB+1];

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            if (sb4_out[6*CB+2+k]) begin
                sum[k] = (CB+2)'($signed(sb4_out[k*CB +: CB])) - $signed({1'b0, quo[k]});
            end else begin
                sum[k] = (CB+2)'($signed(sb4_out[k*CB +: CB])) + $signed({1'b0, quo[k]});
            end
            if (sum[k] > HI) begin
                near[k] = HI[CB-1:0];
            end else if (sum[k] < LO) begin
                near[k] = LO[CB-1:0];
            end else begin
                near[k] = sum[k][CB-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_reg      <= {vld_reg[TOT-2:0], q_ctl.valid};
            m_tvalid_reg <= vld_reg[TOT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_found_reg <= found;
            for (int k = 0; k < 6; k++) begin
                m_near_reg[k] <= found ? near[k] : '0;
            end
        end
    end

    always_comb begin
        m_tdata = '0;
        for (int k = 0; k < 6; k++) begin
            m_tdata[k*CB +: CB] = m_near_reg[k];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_found_reg;

    ap_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> m_tdata == '0)
        else $error("invalid result carries nonzero points");

    ap_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

endmodule

>>> tb/sv/tb_line_line_closest_points.sv
// Testbench for line_line_closest_points: random and directed line pairs are sent in,
// and each result beat is checked against a wide-integer closest-points predictor.
// Depends on llcp_pkg and the line_line_closest_points RTL.
module tb_line_line_closest_points;
    timeunit 1ns;
    timeprecision 1ps;
    import llcp_pkg::*;

    localparam int CB = LANE_BITS;
    localparam int LIMIT_CYCLES = 600000;

    typedef logic signed [199:0] wide_t;
    typedef struct {
        logic [6*CB-1:0] pts;
        logic            found;
    } nearest_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [12*CB-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [6*CB-1:0] m_tdata;
    logic m_tuser;

    logic [12*CB-1:0] query_q[$];
    nearest_t nearest_q[$];
    int err_cnt = 0;
    int result_cnt = 0;
    int cycle_cnt = 0;
    bit fill_done = 0;
    bit long_hold_done = 0;
    int send_gap = 0;
    int hold_cnt = 0;
    logic quiet;

    always #2 aclk = ~aclk;

    line_line_closest_points dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    assign quiet = fill_done && query_q.size() < 150;

    function automatic wide_t dot3(wide_t u[3], wide_t v[3]);
        return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
    endfunction

    // base + round(num*d/den), ties away from zero, saturated to the coordinate range
    function automatic logic [CB-1:0] offset_point(wide_t base, wide_t num, wide_t d,
                                                   wide_t den);
        wide_t t, at, ad, q, s;
        wide_t lim = wide_t'(1) <<< CB;
        wide_t hi = (wide_t'(1) <<< (CB - 1)) - 1;
        wide_t lo = -hi - 1;
        t = num * d;
        at = t < 0 ? -t : t;
        ad = den < 0 ? -den : den;
        q = (2 * at + ad) / (2 * ad);
        if (q > lim) q = lim;
        s = ((t < 0) != (den < 0)) ? base - q : base + q;
        if (s > hi) s = hi;
        if (s < lo) s = lo;
        return s[CB-1:0];
    endfunction

    function automatic nearest_t closest_points(logic [12*CB-1:0] q);
        wide_t a0[3], a1[3], b0[3], b1[3], d13[3], d43[3], d21[3];
        wide_t e1343, e4321, e1321, e4343, e2121, den, numa, numb;
        nearest_t r;
        r.pts = '0;
        r.found = 1'b0;
        for (int i = 0; i < 3; i++) begin
            a0[i] = $signed(q[CB*i +: CB]);
            a1[i] = $signed(q[CB*(3+i) +: CB]);
            b0[i] = $signed(q[CB*(6+i) +: CB]);
            b1[i] = $signed(q[CB*(9+i) +: CB]);
            d13[i] = a0[i] - b0[i];
            d43[i] = b1[i] - b0[i];
            d21[i] = a1[i] - a0[i];
        end
        e1343 = dot3(d13, d43);
        e4321 = dot3(d43, d21);
        e1321 = dot3(d13, d21);
        e4343 = dot3(d43, d43);
        e2121 = dot3(d21, d21);
        if (e4343 == 0 || e2121 == 0) return r;
        den = e2121 * e4343 - e4321 * e4321;
        if (den == 0) return r;
        numa = e1343 * e4321 - e1321 * e4343;
        numb = e1343 * e2121 - e4321 * e1321;
        for (int i = 0; i < 3; i++) begin
            r.pts[CB*i +: CB] = offset_point(a0[i], numa, d21[i], den);
            r.pts[CB*(3+i) +: CB] = offset_point(b0[i], numb, d43[i], den);
        end
        r.found = 1'b1;
        return r;
    endfunction

    function automatic logic [CB-1:0] rnd_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return CB'($signed($urandom_range(0, 2**21)) - 2**20);
            default: return CB'($signed($urandom_range(0, 600)) - 300);
        endcase
    endfunction

    function automatic logic [12*CB-1:0] make_query(logic [CB-1:0] c[12]);
        logic [12*CB-1:0] q;
        for (int i = 0; i < 12; i++) q[CB*i +: CB] = c[i];
        return q;
    endfunction

    function automatic logic [12*CB-1:0] random_query();
        logic [CB-1:0] c[12];
        int mode, kind, k;
        mode = $urandom_range(0, 2);
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 12; i++) c[i] = rnd_coord(mode);
        k = $signed($urandom_range(0, 6)) - 3;
        case (kind)
            0: for (int i = 0; i < 3; i++) c[3+i] = c[i];          // zero-length A
            1: for (int i = 0; i < 3; i++) c[9+i] = c[6+i];        // zero-length B
            2: begin                                              // parallel
                for (int i = 0; i < 3; i++) begin
                    c[i] = rnd_coord(2);
                    c[3+i] = rnd_coord(2);
                    c[9+i] = c[6+i] + k * (c[3+i] - c[i]);
                end
            end
            3: begin                                              // nearly parallel
                for (int i = 0; i < 3; i++) begin
                    c[3+i] = c[i] + rnd_coord(2);
                    c[9+i] = c[6+i] + 2 * (c[3+i] - c[i]);
                end
                c[11] = c[11] + 1;
            end
            default: ;
        endcase
        return make_query(c);
    endfunction

    // driver
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) nearest_q.push_back(closest_points(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 9) == 0) begin
                    send_gap <= $urandom_range(0, 9);
                    s_tvalid <= 1'b0;
                end else if (query_q.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= query_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (nearest_q.size() == 0) begin
                    err_cnt <= err_cnt + 1;
                    if (err_cnt < 10) $display("unexpected result beat %h", m_tdata);
                end else begin
                    nearest_t e;
                    bit bad;
                    e = nearest_q.pop_front();
                    bad = (m_tuser !== e.found);
                    for (int i = 0; i < 6; i++)
                        if (m_tdata[CB*i +: CB] !== e.pts[CB*i +: CB]) bad = 1;
                    if (bad) begin
                        err_cnt <= err_cnt + 1;
                        if (err_cnt < 10)
                            $display("result %0d: exp found=%b %h, got found=%b %h",
                                     result_cnt, e.found, e.pts, m_tuser, m_tdata);
                    end
                end
                result_cnt <= result_cnt + 1;
            end
            if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                m_tready <= 1'b0;
            end else if (!long_hold_done && result_cnt >= 600) begin
                long_hold_done <= 1;
                hold_cnt <= 300;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                hold_cnt <= $urandom_range(0, 9);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("tb_line_line_closest_points: done, errors");
            $finish;
        end
    end

    initial begin
        logic [CB-1:0] c[12];
        logic [CB-1:0] mx, mn;
        mx = {1'b0, {(CB-1){1'b1}}};
        mn = {1'b1, {(CB-1){1'b0}}};
        // all zero
        for (int i = 0; i < 12; i++) c[i] = '0;
        query_q.push_back(make_query(c));
        // extremes of every field
        for (int i = 0; i < 12; i++) c[i] = (i % 2) ? mx : mn;
        query_q.push_back(make_query(c));
        for (int i = 0; i < 12; i++) c[i] = (i % 3) ? mn : mx;
        query_q.push_back(make_query(c));
        for (int i = 0; i < 12; i++) c[i] = (i < 6) ? mx : mn;
        query_q.push_back(make_query(c));
        for (int i = 0; i < 12; i++) c[i] = {CB{1'b1}};
        c[3] = mx; c[10] = mn;
        query_q.push_back(make_query(c));
        // crossing axes: x axis and a line along y through (1,0,1)
        c = '{0, 0, 0, 32'h10000, 0, 0, 32'h10000, 0, 32'h10000,
              32'h10000, 32'h10000, 32'h10000};
        query_q.push_back(make_query(c));
        // zero-length A, zero-length B
        c = '{5, 6, 7, 5, 6, 7, 1, 2, 3, 9, 9, 9};
        query_q.push_back(make_query(c));
        c = '{5, 6, 7, 8, 1, 2, 1, 2, 3, 1, 2, 3};
        query_q.push_back(make_query(c));
        // parallel, and parallel but opposite
        c = '{0, 0, 0, 1, 2, 3, 7, 7, 7, 9, 11, 13};
        query_q.push_back(make_query(c));
        c = '{0, 0, 0, 1, 2, 3, 7, 7, 7, 5, 3, 1};
        query_q.push_back(make_query(c));
        // nearly parallel, then full-range diagonals
        c = '{0, 0, 0, 1, 0, 0, 0, mx, 0, 32'h40000000, mx, 1};
        query_q.push_back(make_query(c));
        c = '{mn, mn, mn, mx, mx, mx, mx, mn, mx, mn, mx, mn};
        query_q.push_back(make_query(c));
        for (int n = 0; n < 10; n++) query_q.push_back(random_query());

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        // sender pause: let every directed result drain first
        wait (query_q.size() == 0 && nearest_q.size() == 0 && !s_tvalid);
        @(posedge aclk);
        for (int n = 0; n < 1730; n++) query_q.push_back(random_query());
        fill_done = 1;
        wait (query_q.size() == 0 && !s_tvalid && nearest_q.size() == 0);
        repeat (100) @(posedge aclk);
        if (err_cnt == 0 && nearest_q.size() == 0) begin
            $display("tb_line_line_closest_points: done, clean");
        end else begin
            $display("tb_line_line_closest_points: done, errors");
        end
        $finish;
    end
endmodule

>>> sim.f
src/llcp_pkg.sv
src/llcp_delay.sv
src/llcp_mul.sv
src/llcp_div.sv
src/llcp_front.sv
src/llcp_back.sv
src/line_line_closest_points.sv
tb/sv/tb_line_line_closest_points.sv
